// ===== design/float_matrix_vector_transform_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the float matrix-vector transform unit
// Shared forms for concurrent checks, clocked on a rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FLOAT_MATRIX_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define FLOAT_MATRIX_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FMVT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FMVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fmvt_pkg.sv =====
// ----------------------------------------------------------------------------
// fmvt_pkg
// Item types, command codes and float32 multiply / add / round helpers.
// ----------------------------------------------------------------------------
package fmvt_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_XFORM = 2'd1,
    CMD_DOT   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam int          STAGES    = 9;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  matrix_index;
    logic [31:0] matrix_value;
    logic [31:0] vec_a0;
    logic [31:0] vec_a1;
    logic [31:0] vec_a2;
    logic [31:0] vec_a3;
    logic [31:0] vec_b0;
    logic [31:0] vec_b1;
    logic [31:0] vec_b2;
    logic [31:0] vec_b3;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res0;
    logic [31:0] res1;
    logic [31:0] res2;
    logic [31:0] res3;
  } out_item_t;

  // Unrounded result: sig bit 50 weighs 2^(exp-127).
  typedef struct packed {
    logic               special;
    logic [31:0]        sval;
    logic               sign;
    logic signed [11:0] exp;
    logic [50:0]        sig;
  } rnd_t;

  typedef struct packed {
    logic        dot;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
  } side_t;

  function automatic rnd_t fmul_pre(logic [31:0] a, logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb, xa, xb;
    logic [22:0] fa, fb;
    logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
    logic [47:0] p;
    rnd_t        r;
    s = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    nan_a = (ea == 8'hFF) && (fa != '0);
    nan_b = (eb == 8'hFF) && (fb != '0);
    inf_a = (ea == 8'hFF) && (fa == '0);
    inf_b = (eb == 8'hFF) && (fb == '0);
    zer_a = (ea == 8'h00) && (fa == '0);
    zer_b = (eb == 8'h00) && (fb == '0);
    xa = (ea == 8'h00) ? 8'd1 : ea;
    xb = (eb == 8'h00) ? 8'd1 : eb;
    p = 48'({ea != 8'h00, fa}) * 48'({eb != 8'h00, fb});
    r = '0;
    r.sign = s;
    r.exp = $signed({4'b0, xa}) + $signed({4'b0, xb}) - 12'sd126;
    r.sig = {p, 3'b000};
    if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) begin
      r.special = 1'b1;
      r.sval = CANON_NAN;
    end else if (inf_a || inf_b) begin
      r.special = 1'b1;
      r.sval = {s, 8'hFF, 23'b0};
    end else if (zer_a || zer_b) begin
      r.special = 1'b1;
      r.sval = {s, 31'b0};
    end
    return r;
  endfunction

  function automatic rnd_t fadd_pre(logic [31:0] a, logic [31:0] b);
    logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [50:0] big, sm, sh, sum;
    logic        st;
    rnd_t        r;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    zer_a = (a[30:0] == '0);
    zer_b = (b[30:0] == '0);
    // order by magnitude so the larger operand is x
    if (a[30:0] < b[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
    d = ex - ey;
    big = {1'b0, x[30:23] != 8'h00, x[22:0], 26'b0};
    sm = {1'b0, y[30:23] != 8'h00, y[22:0], 26'b0};
    if (d >= 8'd51) begin
      sh = '0;
      st = (sm != '0);
    end else begin
      sh = sm >> d;
      st = ((sm << (8'd51 - d)) != '0);
    end
    sh[0] = sh[0] | st;
    sum = (x[31] == y[31]) ? (big + sh) : (big - sh);
    r = '0;
    r.sign = x[31];
    r.exp = $signed({4'b0, ex}) + 12'sd1;
    r.sig = sum;
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      r.special = 1'b1;
      r.sval = CANON_NAN;
    end else if (inf_a) begin
      r.special = 1'b1;
      r.sval = a;
    end else if (inf_b) begin
      r.special = 1'b1;
      r.sval = b;
    end else if (zer_a && zer_b) begin
      r.special = 1'b1;
      r.sval = {a[31] & b[31], 31'b0};
    end else if (sum == '0) begin
      r.special = 1'b1;
      r.sval = 32'h0;
    end
    return r;
  endfunction

  // Normalize, denormalize when tiny, round to nearest even, pack.
  function automatic logic [31:0] round_pack(rnd_t r);
    logic [5:0]         lz, rs;
    logic signed [12:0] e, ef, lzs;
    logic [50:0]        s;
    logic               st, inc;
    logic [30:0]        mag;
    lz = '0;
    for (int i = 0; i < 51; i++) begin
      if (r.sig[i]) lz = 6'(50 - i);
    end
    e = {r.exp[11], r.exp};
    lzs = {7'b0, lz};
    st = 1'b0;
    rs = '0;
    if (e - lzs >= 13'sd1) begin
      s = r.sig << lz;
      ef = e - lzs;
    end else if (e >= 13'sd1) begin
      s = r.sig << 6'(e - 13'sd1);
      ef = '0;
    end else begin
      if (e < -13'sd49) rs = 6'd51;
      else rs = 6'(13'sd1 - e);
      s = r.sig >> rs;
      st = ((r.sig << (6'd51 - rs)) != '0);
      ef = '0;
    end
    st = st | (s[25:0] != '0);
    inc = s[26] & (st | s[27]);
    mag = {ef[7:0], s[49:27]} + 31'(inc);
    if (r.special) return r.sval;
    if (r.sig == '0) return {r.sign, 31'b0};
    if (ef >= 13'sd255) return {r.sign, 8'hFF, 23'b0};
    return {r.sign, mag};
  endfunction

endpackage

// ===== design/float_matrix_vector_transform_unit.sv =====
// ----------------------------------------------------------------------------
// float_matrix_vector_transform_unit
// 4x4 float32 matrix times 4-vector, and 4-element inner product.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------
//  item     | in        | item_valid / item_stall    | fmvt_pkg::in_item_t
//  result   | out       | result_valid / result_stall| fmvt_pkg::out_item_t
//
//  One item per cycle while item_stall is low; a transform or inner product
//  passes capture, 2 multiply stages and 3 adds of 2 stages each, then leaves.
//  Loads write the matrix at acceptance and give no result; command 3 is dropped.
//  Each stage advances when the stage after it is empty or advancing, so
//  bubbles close up and a stalled result holds while earlier stages fill.
//  item_stall rises only when all nine stages hold an item.
//  Reset clears the valid bits only; the matrix is undefined until loaded.
//
`include "float_matrix_vector_transform_unit_defines.svh"

module float_matrix_vector_transform_unit (
  input  logic                clk,
  input  logic                rst,
  input  fmvt_pkg::in_item_t  item,
  input  logic                item_valid,
  output logic                item_stall,
  output fmvt_pkg::out_item_t result,
  output logic                result_valid,
  input  logic                result_stall
);

  localparam int N = fmvt_pkg::STAGES;

  // column-major matrix: row r, column c at index c*4 + r
  logic [31:0] matrix [16];

  logic [N-1:0] v;
  logic [N-1:0] en;
  fmvt_pkg::side_t side [N-1];

  // stage payloads
  logic [3:0][3:0][31:0]        opx, opy;   // stage 0
  fmvt_pkg::rnd_t [3:0][3:0]    mpre;       // stage 1
  logic [3:0][3:0][31:0]        prod;       // stage 2
  fmvt_pkg::rnd_t [3:0]         ad1;        // stage 3
  logic [3:0][1:0][31:0]        p23_3;
  logic [3:0][31:0]             sum1;       // stage 4
  logic [3:0][1:0][31:0]        p23_4;
  fmvt_pkg::rnd_t [3:0]         ad2;        // stage 5
  logic [3:0][31:0]             p3_5;
  logic [3:0][31:0]             sum2;       // stage 6
  logic [3:0][31:0]             p3_6;
  fmvt_pkg::rnd_t [3:0]         ad3;        // stage 7
  fmvt_pkg::out_item_t          out_reg;    // stage 8

  logic accept;
  logic v0_next;
  fmvt_pkg::cmd_t cmd;
  logic [3:0][3:0][31:0] opx_next, opy_next;
  logic [3:0][31:0] sum3;

  assign cmd    = fmvt_pkg::cmd_t'(item.command);
  assign accept = item_valid && !item_stall;
  assign v0_next = accept && ((cmd == fmvt_pkg::CMD_XFORM) || (cmd == fmvt_pkg::CMD_DOT));

  // advance chain: a stage moves when empty or when its successor moves
  always_comb begin
    en[N-1] = !v[N-1] || !result_stall;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign item_stall   = !en[0];
  assign result_valid = v[N-1];
  assign result       = out_reg;

  // lane operands: transform uses matrix rows against a; inner product puts
  // a.b on lane 3 and passes a0..a2 through
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        opx_next[r][c] = matrix[4'(c*4 + r)];
      end
      opy_next[r][0] = item.vec_a0;
      opy_next[r][1] = item.vec_a1;
      opy_next[r][2] = item.vec_a2;
      opy_next[r][3] = item.vec_a3;
    end
    if (cmd == fmvt_pkg::CMD_DOT) begin
      opx_next[3][0] = item.vec_a0;
      opx_next[3][1] = item.vec_a1;
      opx_next[3][2] = item.vec_a2;
      opx_next[3][3] = item.vec_a3;
      opy_next[3][0] = item.vec_b0;
      opy_next[3][1] = item.vec_b1;
      opy_next[3][2] = item.vec_b2;
      opy_next[3][3] = item.vec_b3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd == fmvt_pkg::CMD_LOAD)) begin
      matrix[item.matrix_index] <= item.matrix_value;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= v0_next;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      opx <= opx_next;
      opy <= opy_next;
      side[0] <= '{dot: (cmd == fmvt_pkg::CMD_DOT), a0: item.vec_a0,
                   a1: item.vec_a1, a2: item.vec_a2};
    end
    for (int k = 1; k < N - 1; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // multiply: product and exponent, then round
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mpre[r][c] <= fmvt_pkg::fmul_pre(opx[r][c], opy[r][c]);
        end
      end
    end
    if (en[2]) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= fmvt_pkg::round_pack(mpre[r][c]);
        end
      end
    end
  end

  // sum left to right: ((p0 + p1) + p2) + p3
  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      if (en[3]) begin
        ad1[r] <= fmvt_pkg::fadd_pre(prod[r][0], prod[r][1]);
        p23_3[r][0] <= prod[r][2];
        p23_3[r][1] <= prod[r][3];
      end
      if (en[4]) begin
        sum1[r] <= fmvt_pkg::round_pack(ad1[r]);
        p23_4[r] <= p23_3[r];
      end
      if (en[5]) begin
        ad2[r] <= fmvt_pkg::fadd_pre(sum1[r], p23_4[r][0]);
        p3_5[r] <= p23_4[r][1];
      end
      if (en[6]) begin
        sum2[r] <= fmvt_pkg::round_pack(ad2[r]);
        p3_6[r] <= p3_5[r];
      end
      if (en[7]) begin
        ad3[r] <= fmvt_pkg::fadd_pre(sum2[r], p3_6[r]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum3[r] = fmvt_pkg::round_pack(ad3[r]);
    end
  end

  // output register: inner product keeps a0..a2 as they came in
  always_ff @(posedge clk) begin
    if (en[N-1]) begin
      if (side[N-2].dot) begin
        out_reg <= '{res0: side[N-2].a0, res1: side[N-2].a1,
                     res2: side[N-2].a2, res3: sum3[3]};
      end else begin
        out_reg <= '{res0: sum3[0], res1: sum3[1], res2: sum3[2], res3: sum3[3]};
      end
    end
  end

  `FMVT_ASSERT_NOW(a_stall_full, clk, rst, item_stall, (&v), "input stalled with a free stage")
  `FMVT_ASSERT_NEXT(a_hold_result, clk, rst, (result_valid && result_stall), result_valid, "stalled result dropped")
  `FMVT_ASSERT_NEXT(a_load_silent, clk, rst, (accept && (cmd == fmvt_pkg::CMD_LOAD)), !v[0], "load entered the pipeline")
  `FMVT_ASSERT_NEXT(a_work_enters, clk, rst, (accept && (cmd == fmvt_pkg::CMD_XFORM)), v[0], "transform not captured")

endmodule
